@@ hdl/quaternion_to_euler_angles_core_assert.svh @@
// assertion macros for the quaternion to euler angles core
`ifndef QUATERNION_TO_EULER_ANGLES_CORE_ASSERT_SVH
`define QUATERNION_TO_EULER_ANGLES_CORE_ASSERT_SVH

`ifndef SYNTH
// checked while out of reset
`define QTE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked on every edge, reset included
`define QTE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define QTE_ASSERT(lbl, prop, msg)
`define QTE_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

@@ hdl/qte_pkg.sv @@
package qte_pkg;

  localparam int QUAT_W      = 32;
  localparam int YAW_W       = 31;
  localparam int PITCH_W     = 30;
  localparam int ROLL_W      = 31;
  localparam int QFB_DEF     = 30;
  localparam int AFB_DEF     = 28;
  localparam int IN_DATA_W   = 4 * QUAT_W;
  localparam int OUT_DATA_W  = 96;

  localparam int WIDE_W      = 64;
  localparam int CW          = 44;
  localparam int CORD_STEPS  = 42;
  // normalize (4), fold (1), micro-rotations, round (1), clamp (1)
  localparam int CORD_LAT    = CORD_STEPS + 7;
  localparam int ISQ_STEPS   = 31;
  localparam int ISQ_IN_W    = 61;
  localparam int ISQ_OUT_W   = 31;

  localparam logic signed [63:0] PI_Q60 = 64'sh3243F6A8885A308D;

  typedef struct packed {
    logic signed [WIDE_W-1:0] y;
    logic signed [WIDE_W-1:0] x;
  } qte_pair_t;

  // restoring long division, only used while building the angle table
  function automatic logic [63:0] udiv_const(input logic [63:0] num,
                                             input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] rem;
    q   = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem  = rem - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(2^-i) in q60, power series for i >= 1
  function automatic logic signed [63:0] elem_angle(input int i);
    logic signed [63:0] sum;
    logic signed [63:0] term;
    int n;
    sum = '0;
    if (i == 0) begin
      sum = PI_Q60 >>> 2;
    end else begin
      for (int k = 0; k < 31; k++) begin
        n = i * (2 * k + 1);
        if (n <= 60) begin
          term = udiv_const(64'd1 << (60 - n), 64'(2 * k + 1));
          sum = ((k & 1) == 1) ? sum - term : sum + term;
        end
      end
    end
    return sum;
  endfunction

  // q60 limit rounded half up to afb fraction bits
  function automatic logic signed [63:0] round_lim(input logic signed [63:0] lim,
                                                   input int afb);
    return (lim + (64'sd1 <<< (59 - afb))) >>> (60 - afb);
  endfunction

endpackage

@@ hdl/quaternion_to_euler_angles_core.sv @@
// throughput: one transaction per cycle; every stage advances together and the
//   whole pipe holds while a result waits on out_tready
// depth set by the 31-step square root ahead of the 42-step cordic rotators
// reset: synchronous active-low rst_n clears all valid bits, no data reset
`include "quaternion_to_euler_angles_core_assert.svh"

module quaternion_to_euler_angles_core
  import qte_pkg::*;
#(
  parameter int QUAT_FRAC_BITS  = QFB_DEF,
  parameter int ANGLE_FRAC_BITS = AFB_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // quat_w [31:0], quat_x [63:32], quat_y [95:64], quat_z [127:96]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // yaw_angle [30:0], pitch_angle [60:31], roll_angle [91:61], zero [95:92]
  output logic [OUT_DATA_W-1:0] out_tdata,
  // pitch_saturated [0]
  output logic                  out_tuser
);

  localparam logic signed [63:0] YAW_LIM   = round_lim(PI_Q60, ANGLE_FRAC_BITS);
  localparam logic signed [63:0] PITCH_LIM = round_lim(PI_Q60 >>> 1, ANGLE_FRAC_BITS);

  logic                      adv;
  logic                      f_vld, f_sat;
  qte_pair_t                 yaw_pair, roll_pair, pitch_pair;
  logic signed [YAW_W-1:0]   yaw;
  logic signed [PITCH_W-1:0] pitch;
  logic signed [ROLL_W-1:0]  roll;
  logic [CORD_LAT-1:0]       vld_r;
  logic [CORD_LAT-1:0]       sat_r;

  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  qte_front #(
    .QFB (QUAT_FRAC_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .in_vld     (in_tvalid),
    .quat_w     (in_tdata[31:0]),
    .quat_x     (in_tdata[63:32]),
    .quat_y     (in_tdata[95:64]),
    .quat_z     (in_tdata[127:96]),
    .out_vld    (f_vld),
    .out_sat    (f_sat),
    .yaw_pair   (yaw_pair),
    .roll_pair  (roll_pair),
    .pitch_pair (pitch_pair)
  );

  qte_cordic #(
    .AFB     (ANGLE_FRAC_BITS),
    .OUT_W   (YAW_W),
    .LIM_Q60 (PI_Q60)
  ) u_yaw (
    .clk     (clk),
    .adv     (adv),
    .pair_i  (yaw_pair),
    .angle_o (yaw)
  );

  qte_cordic #(
    .AFB     (ANGLE_FRAC_BITS),
    .OUT_W   (PITCH_W),
    .LIM_Q60 (PI_Q60 >>> 1)
  ) u_pitch (
    .clk     (clk),
    .adv     (adv),
    .pair_i  (pitch_pair),
    .angle_o (pitch)
  );

  qte_cordic #(
    .AFB     (ANGLE_FRAC_BITS),
    .OUT_W   (ROLL_W),
    .LIM_Q60 (PI_Q60)
  ) u_roll (
    .clk     (clk),
    .adv     (adv),
    .pair_i  (roll_pair),
    .angle_o (roll)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[CORD_LAT-2:0], f_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sat_r <= {sat_r[CORD_LAT-2:0], f_sat};
    end
  end

  assign out_tvalid = vld_r[CORD_LAT-1];
  assign out_tuser  = sat_r[CORD_LAT-1];
  assign out_tdata  = {4'b0000, roll, pitch, yaw};

  `QTE_ASSERT_ALWAYS(a_reset_empties, !rst_n |=> !out_tvalid, "result valid after reset")
  `QTE_ASSERT(a_sat_pins_pitch, out_tvalid && out_tuser |-> (pitch == PITCH_LIM || pitch == -PITCH_LIM), "saturated pitch not at limit")
  `QTE_ASSERT(a_yaw_range, out_tvalid |-> (yaw <= YAW_LIM && yaw >= -YAW_LIM), "yaw beyond pi")

endmodule

@@ hdl/qte_isqrt.sv @@
module qte_isqrt
  import qte_pkg::*;
(
  input  logic                 clk,
  input  logic                 adv,
  input  logic [ISQ_IN_W-1:0]  v_i,
  output logic [ISQ_OUT_W-1:0] root_o
);

  localparam int VW = 62;

  logic [VW-1:0] v_r [0:ISQ_STEPS];
  logic [VW-1:0] r_r [0:ISQ_STEPS];

  assign v_r[0] = VW'(v_i);
  assign r_r[0] = '0;

  // one result bit per stage, test bit 4^k with k from high to low
  for (genvar j = 0; j < ISQ_STEPS; j++) begin : g_step
    localparam logic [VW-1:0] B = VW'(1) << (2 * (ISQ_STEPS - 1 - j));
    logic [VW-1:0] t;
    logic [VW-1:0] v_nxt;
    logic [VW-1:0] r_nxt;

    always_comb begin
      t = r_r[j] + B;
      if (v_r[j] >= t) begin
        v_nxt = v_r[j] - t;
        r_nxt = (r_r[j] >> 1) + B;
      end else begin
        v_nxt = v_r[j];
        r_nxt = r_r[j] >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        v_r[j+1] <= v_nxt;
        r_r[j+1] <= r_nxt;
      end
    end
  end

  assign root_o = r_r[ISQ_STEPS][ISQ_OUT_W-1:0];

endmodule

@@ hdl/qte_front.sv @@
module qte_front
  import qte_pkg::*;
#(
  parameter int QFB = QFB_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     adv,
  input  logic                     in_vld,
  input  logic signed [QUAT_W-1:0] quat_w,
  input  logic signed [QUAT_W-1:0] quat_x,
  input  logic signed [QUAT_W-1:0] quat_y,
  input  logic signed [QUAT_W-1:0] quat_z,
  output logic                     out_vld,
  output logic                     out_sat,
  output qte_pair_t                yaw_pair,
  output qte_pair_t                roll_pair,
  output qte_pair_t                pitch_pair
);

  localparam logic signed [63:0] UNIT = 64'sd1 <<< (2 * QFB - 2);
  localparam int DLY = ISQ_STEPS + 2;

  typedef struct packed {
    logic             sat;
    qte_pair_t        yaw;
    qte_pair_t        roll;
    logic signed [31:0] s30;
  } dly_t;

  // stage 1: products
  logic                     vld1_r;
  logic signed [63:0]       ww_r, xx_r, zz_r, wz_r, xy_r, wx_r, yz_r, wy_r, xz_r;

  // stage 2: sums
  logic                     vld2_r;
  logic signed [63:0]       yyn_r, yxd_r, ryn_r, rxd_r, sd_r;

  // stage 3: clamp and requantize
  logic                     vld3_r;
  dly_t                     f3_r;
  logic signed [63:0]       s_cl;
  logic                     sat_nxt;
  logic signed [31:0]       s30_nxt;

  // stages 4, 5: square and complement
  logic signed [63:0]       sq_r;
  logic [ISQ_IN_W-1:0]      v_r;
  logic [ISQ_OUT_W-1:0]     root;

  dly_t                     dly_r [0:DLY-1];
  logic [DLY-1:0]           dly_vld_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      ww_r <= 64'(quat_w * quat_w);
      xx_r <= 64'(quat_x * quat_x);
      zz_r <= 64'(quat_z * quat_z);
      wz_r <= 64'(quat_w * quat_z);
      xy_r <= 64'(quat_x * quat_y);
      wx_r <= 64'(quat_w * quat_x);
      yz_r <= 64'(quat_y * quat_z);
      wy_r <= 64'(quat_w * quat_y);
      xz_r <= 64'(quat_x * quat_z);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      yyn_r <= (wz_r >>> 1) + (xy_r >>> 1);
      yxd_r <= (ww_r >>> 1) + (xx_r >>> 1) - UNIT;
      ryn_r <= (wx_r >>> 1) + (yz_r >>> 1);
      rxd_r <= (ww_r >>> 1) + (zz_r >>> 1) - UNIT;
      sd_r  <= (wy_r >>> 1) - (xz_r >>> 1);
    end
  end

  always_comb begin
    if (sd_r > UNIT) begin
      s_cl    = UNIT;
      sat_nxt = 1'b1;
    end else if (sd_r < -UNIT) begin
      s_cl    = -UNIT;
      sat_nxt = 1'b1;
    end else begin
      s_cl    = sd_r;
      sat_nxt = 1'b0;
    end
  end

  // arcsine argument brought to q30
  if (QFB >= 16) begin : g_s30_down
    assign s30_nxt = 32'(s_cl >>> (2 * QFB - 32));
  end else begin : g_s30_up
    assign s30_nxt = 32'(s_cl <<< (32 - 2 * QFB));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f3_r.sat    <= sat_nxt;
      f3_r.yaw    <= '{y: yyn_r, x: yxd_r};
      f3_r.roll   <= '{y: ryn_r, x: rxd_r};
      f3_r.s30    <= s30_nxt;
      sq_r        <= 64'(f3_r.s30 * f3_r.s30);
      v_r         <= (ISQ_IN_W'(1) << 60) - sq_r[ISQ_IN_W-1:0];
      dly_r[0]    <= f3_r;
      for (int i = 1; i < DLY; i++) begin
        dly_r[i] <= dly_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r    <= 1'b0;
      vld2_r    <= 1'b0;
      vld3_r    <= 1'b0;
      dly_vld_r <= '0;
    end else if (adv) begin
      vld1_r    <= in_vld;
      vld2_r    <= vld1_r;
      vld3_r    <= vld2_r;
      dly_vld_r <= {dly_vld_r[DLY-2:0], vld3_r};
    end
  end

  qte_isqrt u_isqrt (
    .clk    (clk),
    .adv    (adv),
    .v_i    (v_r),
    .root_o (root)
  );

  assign out_vld      = dly_vld_r[DLY-1];
  assign out_sat      = dly_r[DLY-1].sat;
  assign yaw_pair     = dly_r[DLY-1].yaw;
  assign roll_pair    = dly_r[DLY-1].roll;
  assign pitch_pair.y = WIDE_W'(dly_r[DLY-1].s30);
  assign pitch_pair.x = {{(WIDE_W - ISQ_OUT_W){1'b0}}, root};

endmodule

@@ hdl/qte_cordic.sv @@
module qte_cordic
  import qte_pkg::*;
#(
  parameter int                 AFB     = AFB_DEF,
  parameter int                 OUT_W   = YAW_W,
  parameter logic signed [63:0] LIM_Q60 = PI_Q60
) (
  input  logic                    clk,
  input  logic                    adv,
  input  qte_pair_t               pair_i,
  output logic signed [OUT_W-1:0] angle_o
);

  localparam int                 SH   = 60 - AFB;
  localparam logic signed [63:0] HALF = 64'sd1 <<< (SH - 1);
  localparam logic signed [63:0] LIM  = round_lim(LIM_Q60, AFB);
  localparam logic signed [63:0] NEG40 = -(64'sd1 <<< 40);
  localparam logic signed [63:0] QTR  = PI_Q60 >>> 1;

  // normalize: magnitude, leading one, shift, correction
  logic signed [63:0] a_x_r, a_y_r, b_x_r, b_y_r, c_x_r, c_y_r;
  logic [63:0]        a_m_r;
  logic [63:0]        mx, my;
  logic               a_zero_r, b_zero_r, c_zero_r, d_zero_r;
  logic [5:0]         b_msb_r, msb_nxt;
  logic signed [63:0] c_x_nxt, c_y_nxt, d_x_nxt, d_y_nxt;
  logic signed [CW-1:0] d_x_r, d_y_r;

  logic signed [CW-1:0] f_x_nxt, f_y_nxt;
  logic signed [63:0]   f_z_nxt;

  logic signed [CW-1:0] it_x_r [0:CORD_STEPS];
  logic signed [CW-1:0] it_y_r [0:CORD_STEPS];
  logic signed [63:0]   it_z_r [0:CORD_STEPS];
  logic                 it_zero_r [0:CORD_STEPS];

  logic signed [63:0]   e_r;
  logic signed [63:0]   angle_nxt;

  assign mx = pair_i.x[63] ? 64'(-pair_i.x) : 64'(pair_i.x);
  assign my = pair_i.y[63] ? 64'(-pair_i.y) : 64'(pair_i.y);

  always_comb begin
    msb_nxt = '0;
    for (int i = 0; i < 64; i++) begin
      if (a_m_r[i]) msb_nxt = 6'(i);
    end
  end

  // bring the larger magnitude to bit 39
  always_comb begin
    if (b_msb_r > 6'd39) begin
      c_x_nxt = b_x_r >>> (b_msb_r - 6'd39);
      c_y_nxt = b_y_r >>> (b_msb_r - 6'd39);
    end else begin
      c_x_nxt = b_x_r <<< (6'd39 - b_msb_r);
      c_y_nxt = b_y_r <<< (6'd39 - b_msb_r);
    end
  end

  // a floored negative operand can land on exactly -2^40
  always_comb begin
    if (c_x_r == NEG40 || c_y_r == NEG40) begin
      d_x_nxt = c_x_r >>> 1;
      d_y_nxt = c_y_r >>> 1;
    end else begin
      d_x_nxt = c_x_r;
      d_y_nxt = c_y_r;
    end
  end

  // left half plane folded by a quarter turn
  always_comb begin
    if (d_x_r < 0) begin
      if (d_y_r >= 0) begin
        f_x_nxt = d_y_r;
        f_y_nxt = -d_x_r;
        f_z_nxt = QTR;
      end else begin
        f_x_nxt = -d_y_r;
        f_y_nxt = d_x_r;
        f_z_nxt = -QTR;
      end
    end else begin
      f_x_nxt = d_x_r;
      f_y_nxt = d_y_r;
      f_z_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_x_r        <= pair_i.x;
      a_y_r        <= pair_i.y;
      a_m_r        <= (mx > my) ? mx : my;
      a_zero_r     <= (pair_i.x == 0) && (pair_i.y == 0);
      b_x_r        <= a_x_r;
      b_y_r        <= a_y_r;
      b_msb_r      <= msb_nxt;
      b_zero_r     <= a_zero_r;
      c_x_r        <= c_x_nxt;
      c_y_r        <= c_y_nxt;
      c_zero_r     <= b_zero_r;
      d_x_r        <= d_x_nxt[CW-1:0];
      d_y_r        <= d_y_nxt[CW-1:0];
      d_zero_r     <= c_zero_r;
      it_x_r[0]    <= f_x_nxt;
      it_y_r[0]    <= f_y_nxt;
      it_z_r[0]    <= f_z_nxt;
      it_zero_r[0] <= d_zero_r;
    end
  end

  for (genvar i = 0; i < CORD_STEPS; i++) begin : g_rot
    localparam logic signed [63:0] E = elem_angle(i);
    logic signed [CW-1:0] dx, dy;

    assign dx = it_y_r[i] >>> i;
    assign dy = it_x_r[i] >>> i;

    always_ff @(posedge clk) begin
      if (adv) begin
        if (it_y_r[i] > 0) begin
          it_x_r[i+1] <= it_x_r[i] + dx;
          it_y_r[i+1] <= it_y_r[i] - dy;
          it_z_r[i+1] <= it_z_r[i] + E;
        end else begin
          it_x_r[i+1] <= it_x_r[i] - dx;
          it_y_r[i+1] <= it_y_r[i] + dy;
          it_z_r[i+1] <= it_z_r[i] - E;
        end
        it_zero_r[i+1] <= it_zero_r[i];
      end
    end
  end

  always_comb begin
    if (e_r > LIM) begin
      angle_nxt = LIM;
    end else if (e_r < -LIM) begin
      angle_nxt = -LIM;
    end else begin
      angle_nxt = e_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_r     <= ((it_zero_r[CORD_STEPS] ? 64'sd0 : it_z_r[CORD_STEPS]) + HALF) >>> SH;
      angle_o <= angle_nxt[OUT_W-1:0];
    end
  end

endmodule
